@@ hdl/lefr_pkg.sv @@
package lefr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_ORDER = 4;

    localparam int IN_W   = 24;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;
    localparam int OUT_W  = 32;
    localparam int ACC_W  = 28;
    localparam int U_EXP  = 2 * FRAC_BITS;
    localparam int S_MIN  = (U_EXP > 30) ? (U_EXP - 30) : 0;
    localparam int P_W    = 2 * IN_W;
    localparam int LEN_W  = 6;
    localparam int VS_W   = 31;
    localparam int E_W    = 5;
    localparam int SQ_W   = 2 * VS_W;
    localparam int MUL_W  = ACC_W + VS_W;
    localparam int D_W    = SQ_W + 1;
    localparam int NUM_W  = MUL_W + 2;
    localparam int MAG_W  = NUM_W - 1;
    localparam int QUO_W  = 28;
    localparam int N_W    = MAG_W + 31;
    localparam int RND_W  = P_W + 1 - FRAC_BITS;

    localparam logic [QUO_W-1:0] ACC_LIM = QUO_W'(1) << 26;
    localparam logic [RND_W-1:0] OUT_MAX = RND_W'(32'h7FFF_FFFF);
    localparam logic signed [CFG_W-1:0] GAIN_RESET = CFG_W'(65536);

    typedef enum logic [2:0] {
        KIND_PROP  = 3'd0,
        KIND_LAG1  = 3'd1,
        KIND_LAG2  = 3'd2,
        KIND_LAG3  = 3'd3,
        KIND_LAG4  = 3'd4,
        KIND_DIFF  = 3'd5,
        KIND_INTEG = 3'd6,
        KIND_ZERO  = 3'd7
    } kind_t;

    localparam logic [IDX_W-1:0] CFG_KIND  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_T1    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_T2    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_T3    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_T4    = 3'd5;
    localparam logic [IDX_W-1:0] CFG_INTEG = 3'd6;

    typedef struct packed {
        logic                    valid;
        logic [IN_W-1:0]         omega;
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } item_t;

    // Bit length of the product omega * T.
    function automatic logic [LEN_W-1:0] lead_len(input logic [P_W-1:0] p);
        logic [LEN_W-1:0] len;
        len = '0;
        for (int i = 0; i < P_W; i++)
        begin
            if (p[i])
            begin
                len = LEN_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

@@ hdl/lefr_lag_stage.sv @@
module lefr_lag_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        active,
    input  logic [lefr_pkg::CFG_W-1:0]  tconst,
    input  lefr_pkg::item_t             item_in,
    output lefr_pkg::item_t             item_out
);

    typedef struct packed {
        logic [lefr_pkg::D_W-1:0]   rem;
        logic [lefr_pkg::QUO_W-1:0] sh;
    } part_t;

    typedef struct packed {
        lefr_pkg::item_t          item;
        logic [lefr_pkg::D_W-1:0] d;
        logic                     neg_re;
        logic                     neg_im;
        part_t                    pre;
        part_t                    pim;
    } div_t;

    function automatic part_t div_step(input part_t x, input logic [lefr_pkg::D_W-1:0] d);
        logic [lefr_pkg::D_W:0] wide;
        logic                   q;
        part_t                  y;
        wide = {x.rem, x.sh[lefr_pkg::QUO_W-1]};
        q = (wide >= {1'b0, d});
        y.rem = q ? lefr_pkg::D_W'(wide - {1'b0, d}) : lefr_pkg::D_W'(wide);
        y.sh = {x.sh[lefr_pkg::QUO_W-2:0], q};
        return y;
    endfunction

    function automatic logic signed [lefr_pkg::ACC_W-1:0] finish(
        input logic neg, input logic [lefr_pkg::QUO_W-1:0] q);
        logic [lefr_pkg::QUO_W-1:0] m;
        m = (q > lefr_pkg::ACC_LIM) ? lefr_pkg::ACC_LIM : q;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    lefr_pkg::item_t st1_reg, st2_reg, st3_reg, st4_reg, fin_reg;
    logic [lefr_pkg::P_W-1:0]         p_reg;
    logic [lefr_pkg::E_W-1:0]         e2_reg, e3_reg, e4_reg;
    logic [lefr_pkg::VS_W-1:0]        vs_reg;
    logic [lefr_pkg::SQ_W-1:0]        sq_reg;
    logic signed [lefr_pkg::MUL_W-1:0] a_reg, b_reg;
    logic [lefr_pkg::D_W-1:0]         d_reg;
    logic signed [lefr_pkg::NUM_W-1:0] nre_reg, nim_reg;
    div_t                             div_reg [0:lefr_pkg::QUO_W];

    logic [lefr_pkg::LEN_W-1:0] len;
    logic [lefr_pkg::LEN_W-1:0] shamt;
    logic [lefr_pkg::E_W-1:0]   e_next;
    logic [lefr_pkg::VS_W-1:0]  vs_next;
    logic [lefr_pkg::D_W-1:0]   d_next;
    logic signed [lefr_pkg::NUM_W-1:0] nre_next, nim_next;
    logic [lefr_pkg::MAG_W-1:0] mag_re, mag_im;
    logic [lefr_pkg::N_W-1:0]   num_re, num_im;
    div_t                       div_next;
    lefr_pkg::item_t            fin_next;

    // Common right shift of u and v that brings both below 2^31.
    always_comb
    begin
        len = lefr_pkg::lead_len(p_reg);
        shamt = (len > lefr_pkg::LEN_W'(31 + lefr_pkg::S_MIN)) ?
                lefr_pkg::LEN_W'(len - 31) : lefr_pkg::LEN_W'(lefr_pkg::S_MIN);
        e_next = lefr_pkg::E_W'(lefr_pkg::LEN_W'(lefr_pkg::U_EXP) - shamt);
        vs_next = lefr_pkg::VS_W'(p_reg >> shamt);
    end

    always_comb
    begin
        d_next = (lefr_pkg::D_W'(1) << {e3_reg, 1'b0}) + lefr_pkg::D_W'(sq_reg);
        nre_next = (lefr_pkg::NUM_W'(st3_reg.re) <<< e3_reg)
                 + lefr_pkg::NUM_W'(a_reg);
        nim_next = (lefr_pkg::NUM_W'(st3_reg.im) <<< e3_reg)
                 - lefr_pkg::NUM_W'(b_reg);
    end

    // Rounding adds half the divisor before the long division.
    always_comb
    begin
        mag_re = lefr_pkg::MAG_W'(nre_reg[lefr_pkg::NUM_W-1] ? -nre_reg : nre_reg);
        mag_im = lefr_pkg::MAG_W'(nim_reg[lefr_pkg::NUM_W-1] ? -nim_reg : nim_reg);
        num_re = (lefr_pkg::N_W'(mag_re) << e4_reg) + lefr_pkg::N_W'(d_reg >> 1);
        num_im = (lefr_pkg::N_W'(mag_im) << e4_reg) + lefr_pkg::N_W'(d_reg >> 1);
        div_next.item   = st4_reg;
        div_next.d      = d_reg;
        div_next.neg_re = nre_reg[lefr_pkg::NUM_W-1];
        div_next.neg_im = nim_reg[lefr_pkg::NUM_W-1];
        div_next.pre.rem = num_re[lefr_pkg::N_W-1:lefr_pkg::QUO_W];
        div_next.pre.sh  = num_re[lefr_pkg::QUO_W-1:0];
        div_next.pim.rem = num_im[lefr_pkg::N_W-1:lefr_pkg::QUO_W];
        div_next.pim.sh  = num_im[lefr_pkg::QUO_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_reg <= '0;
            st2_reg <= '0;
            st3_reg <= '0;
            st4_reg <= '0;
            div_reg[0] <= '0;
        end
        else if (en)
        begin
            st1_reg <= item_in;
            st2_reg <= st1_reg;
            st3_reg <= st2_reg;
            st4_reg <= st3_reg;
            div_reg[0] <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg   <= item_in.omega * tconst;
            e2_reg  <= e_next;
            vs_reg  <= vs_next;
            e3_reg  <= e2_reg;
            sq_reg  <= vs_reg * vs_reg;
            a_reg   <= st2_reg.im * $signed({1'b0, vs_reg});
            b_reg   <= st2_reg.re * $signed({1'b0, vs_reg});
            e4_reg  <= e3_reg;
            d_reg   <= d_next;
            nre_reg <= nre_next;
            nim_reg <= nim_next;
        end
    end

    for (genvar k = 0; k < lefr_pkg::QUO_W; k++)
    begin : g_step
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_reg[k+1] <= '0;
            end
            else if (en)
            begin
                div_reg[k+1].item   <= div_reg[k].item;
                div_reg[k+1].d      <= div_reg[k].d;
                div_reg[k+1].neg_re <= div_reg[k].neg_re;
                div_reg[k+1].neg_im <= div_reg[k].neg_im;
                div_reg[k+1].pre    <= div_step(div_reg[k].pre, div_reg[k].d);
                div_reg[k+1].pim    <= div_step(div_reg[k].pim, div_reg[k].d);
            end
        end
    end

    // An inactive section passes the accumulator on untouched.
    always_comb
    begin
        fin_next = div_reg[lefr_pkg::QUO_W].item;
        if (active)
        begin
            fin_next.re = finish(div_reg[lefr_pkg::QUO_W].neg_re,
                                 div_reg[lefr_pkg::QUO_W].pre.sh);
            fin_next.im = finish(div_reg[lefr_pkg::QUO_W].neg_im,
                                 div_reg[lefr_pkg::QUO_W].pim.sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg <= '0;
        end
        else if (en)
        begin
            fin_reg <= fin_next;
        end
    end

    assign item_out = fin_reg;

endmodule

@@ hdl/lefr_out_stage.sv @@
module lefr_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lefr_pkg::item_t             item_in,
    input  lefr_pkg::kind_t             kind,
    input  logic [lefr_pkg::CFG_W-1:0]  integ_time,
    output logic                        en,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [63:0]                 m_axis_tdata,
    output logic [0:0]                  m_axis_tuser
);

    typedef struct packed {
        logic [lefr_pkg::OUT_W-1:0] re;
        logic [lefr_pkg::OUT_W-1:0] im;
        logic                       sat;
    } res_t;

    lefr_pkg::item_t          o1_reg;
    logic [lefr_pkg::P_W-1:0] prod_reg;
    res_t                     res_next;
    res_t                     main_reg, skid_reg;
    logic                     main_valid_reg, skid_valid_reg;
    logic [lefr_pkg::RND_W-1:0] rnd;
    logic                     push, pop;

    assign en = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1_reg <= '0;
        end
        else if (en)
        begin
            o1_reg <= item_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= integ_time * item_in.omega;
        end
    end

    always_comb
    begin
        rnd = lefr_pkg::RND_W'((lefr_pkg::RND_W + lefr_pkg::FRAC_BITS)'(prod_reg)
              + (lefr_pkg::RND_W + lefr_pkg::FRAC_BITS)'(1 << (lefr_pkg::FRAC_BITS - 1))
              >> lefr_pkg::FRAC_BITS);
        res_next = '0;
        case (kind)
            lefr_pkg::KIND_PROP,
            lefr_pkg::KIND_LAG1,
            lefr_pkg::KIND_LAG2,
            lefr_pkg::KIND_LAG3,
            lefr_pkg::KIND_LAG4:
            begin
                if (int'(kind) <= lefr_pkg::MAX_ORDER)
                begin
                    res_next.re = lefr_pkg::OUT_W'(o1_reg.re);
                    if (kind != lefr_pkg::KIND_PROP)
                    begin
                        res_next.im = lefr_pkg::OUT_W'(o1_reg.im);
                    end
                end
            end
            lefr_pkg::KIND_INTEG:
            begin
                if (rnd > lefr_pkg::OUT_MAX)
                begin
                    res_next.im  = lefr_pkg::OUT_W'(lefr_pkg::OUT_MAX);
                    res_next.sat = 1'b1;
                end
                else
                begin
                    res_next.im = lefr_pkg::OUT_W'(rnd);
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    assign push = en && o1_reg.valid;
    assign pop  = main_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                main_reg <= res_next;
            end
        end
    end

    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tdata  = {main_reg.im, main_reg.re};
    assign m_axis_tuser  = main_reg.sat;

endmodule

@@ hdl/lag_element_frequency_response.sv @@
// Frequency response of a proportional element, a lag of order one to four, or an
// integrator, one angular frequency (unsigned Q8.16) per request. Each result gives the
// real and imaginary parts in signed Q16.16 plus a flag that is set when the integrator
// output clipped. The block takes one request per cycle for as long as results are
// taken; requests pass through four lag sections of 34 register stages each, most of
// which are the 28 steps of the restoring divider in every section, plus two output
// stages. A stalled output is held in a one-deep skid register and the input stays
// ready until that register fills. Configuration must be written through the cfg
// port while no request is in flight (not enforced here); the port is always ready.
module lag_element_frequency_response (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] omega
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] real_part, [63:32] imag_part
    output logic [0:0]  m_axis_tuser,   // [0] saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    lefr_pkg::kind_t            kind_reg;
    logic [lefr_pkg::CFG_W-1:0] gain_reg;
    logic [lefr_pkg::CFG_W-1:0] tconst_reg [0:3];
    logic [lefr_pkg::CFG_W-1:0] integ_reg;

    logic            en;
    lefr_pkg::item_t item_in;
    lefr_pkg::item_t lag_item [0:lefr_pkg::MAX_ORDER];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= lefr_pkg::KIND_PROP;
            gain_reg  <= lefr_pkg::GAIN_RESET;
            tconst_reg[0] <= '0;
            tconst_reg[1] <= '0;
            tconst_reg[2] <= '0;
            tconst_reg[3] <= '0;
            integ_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lefr_pkg::CFG_KIND:  kind_reg <= lefr_pkg::kind_t'(cfg_data[2:0]);
                lefr_pkg::CFG_GAIN:  gain_reg <= cfg_data;
                lefr_pkg::CFG_T1:    tconst_reg[0] <= cfg_data;
                lefr_pkg::CFG_T2:    tconst_reg[1] <= cfg_data;
                lefr_pkg::CFG_T3:    tconst_reg[2] <= cfg_data;
                lefr_pkg::CFG_T4:    tconst_reg[3] <= cfg_data;
                lefr_pkg::CFG_INTEG: integ_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = en;

    always_comb
    begin
        item_in.valid = s_axis_tvalid;
        item_in.omega = s_axis_tdata;
        item_in.re    = lefr_pkg::ACC_W'($signed(gain_reg));
        item_in.im    = '0;
    end

    assign lag_item[0] = item_in;

    for (genvar i = 0; i < lefr_pkg::MAX_ORDER; i++)
    begin : g_lag
        lefr_lag_stage u_lag (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .active   (kind_reg >= 3'(i + 1)),
            .tconst   (tconst_reg[i]),
            .item_in  (lag_item[i]),
            .item_out (lag_item[i+1])
        );
    end

    lefr_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_in       (lag_item[lefr_pkg::MAX_ORDER]),
        .kind          (kind_reg),
        .integ_time    (integ_reg),
        .en            (en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ hdl/lefr_checker.sv @@
module lefr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // A held result keeps its value until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Only the integrator clips, and then to the positive limit with no real part.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
        m_axis_tdata[63:32] == 32'h7FFF_FFFF && m_axis_tdata[31:0] == 32'h0)
        else $error("saturated result has wrong value");

    // The input only backs off when a result is waiting.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind lag_element_frequency_response lefr_checker u_lefr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
